/* design/ilir_pkg.sv */
package ilir_pkg;

    // List depth and derived widths.
    localparam int CAPACITY = 16;
    localparam int OP_W     = 3;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 32;
    localparam int OCNT_W   = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // Commands broadcast to the entry cells.
    localparam logic [1:0] CMD_HOLD   = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [VAL_W-1:0]  read_value;
        logic [OCNT_W-1:0] count;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CMP_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

/* design/ilir_cell.sv */
module ilir_cell
    import ilir_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [POS_W-1:0] i_pos,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_entry
);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic [CMP_W-1:0] pos_ext;

    assign pos_ext = CMP_W'(i_pos);

    // Pick the next word: keep it, take the request value, or take a neighbor's word.
    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.cmd)
            CMD_SET: begin
                if (pos_ext == i_cmd.index) n_entry = i_cmd.value;
            end
            CMD_INSERT: begin
                if (pos_ext == i_cmd.index) n_entry = i_cmd.value;
                else if (pos_ext > i_cmd.index) n_entry = i_left;
            end
            CMD_REMOVE: begin
                if (pos_ext >= i_cmd.index) n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // The stored word needs no reset; it is read only after being written.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* design/indexed_list_insert_remove_unit.sv */
// Indexed list unit: an ordered list of up to CAPACITY 32-bit words addressed by position.
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in) and carry get, set,
// add, remove or clear. Each request gives exactly one result on the output channel
// (o_out_valid, i_out_stall, o_out) with ok, the word read by get, and the new count.
// A transaction is taken at a rising edge where valid is high and stall is low.
// Each request is decoded and applied to a row of entry cells in the cycle it is accepted,
// and its result is registered and shown in the next cycle.
// On add or remove the cells from the index upward change in that same cycle, so the
// shift costs no extra time. A new request is accepted every cycle as long as the
// result register is empty or its result is taken in that cycle.
// When the receiver stalls, the result holds and o_in_stall rises until it is taken.
// Reset (synchronous, active low) empties the list and drops any pending result;
// there is no clearing pass, the cell words are simply unused until written.
module indexed_list_insert_remove_unit
    import ilir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    t_cell_cmd        cell_cmd;
    logic             in_accept;
    logic             in_ok;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [VAL_W-1:0] entry_q [CAPACITY];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign idx_ext    = CMP_W'(i_in.index);
    assign cnt_ext    = CMP_W'(r_count);

    // Decode the request into a success flag, a cell command and the next count.
    always_comb begin
        in_ok          = 1'b0;
        n_count        = r_count;
        cell_cmd.cmd   = CMD_HOLD;
        cell_cmd.index = idx_ext;
        cell_cmd.value = i_in.value;
        unique case (i_in.op)
            OP_GET: begin
                in_ok = (idx_ext < cnt_ext);
            end
            OP_SET: begin
                in_ok = (idx_ext < cnt_ext);
                if (in_ok) cell_cmd.cmd = CMD_SET;
            end
            OP_ADD: begin
                in_ok = (idx_ext <= cnt_ext) && (cnt_ext < CMP_W'(CAPACITY));
                if (in_ok) begin
                    cell_cmd.cmd = CMD_INSERT;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                in_ok = (idx_ext < cnt_ext);
                if (in_ok) begin
                    cell_cmd.cmd = CMD_REMOVE;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                in_ok   = 1'b1;
                n_count = '0;
            end
            default: begin
                in_ok = 1'b0;
            end
        endcase
        if (!in_accept) begin
            cell_cmd.cmd = CMD_HOLD;
            n_count      = r_count;
        end
    end

    // Row of entry cells; each neighbor pair is linked both ways for shifting.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VAL_W-1:0] left_word;
        logic [VAL_W-1:0] right_word;
        if (k == 0) begin : g_first
            assign left_word = i_in.value;
        end else begin : g_inner_l
            assign left_word = entry_q[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_word = entry_q[k];
        end else begin : g_inner_r
            assign right_word = entry_q[k+1];
        end
        ilir_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_pos   (POS_W'(k)),
            .i_left  (left_word),
            .i_right (right_word),
            .o_entry (entry_q[k])
        );
    end

    // Form the result from the decoded request and the current cell contents.
    always_comb begin
        logic [CMP_W-1:0] cnt_next_ext;
        cnt_next_ext     = CMP_W'(n_count);
        n_out.ok         = in_ok;
        n_out.read_value = '0;
        if (in_ok && (i_in.op == OP_GET)) begin
            n_out.read_value = entry_q[POS_W'(i_in.index)];
        end
        n_out.count = cnt_next_ext[OCNT_W-1:0];
    end

    // Count and result valid are control state and take the reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_accept) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (in_accept) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in.op == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the list");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in.op == OP_ADD) && in_ok)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("successful add did not grow the list by one");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept) |=> (o_out.count == OCNT_W'(r_count)))
        else $error("result count differs from the list count");
`endif

endmodule
